/* rtl/rmsd_pkg.sv */
package rmsd_pkg;

  localparam int DUR_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int MEAN_W  = DUR_W + FRAC_W;
  localparam int CNT_W   = 16;
  localparam int THR_W   = 16;
  localparam int ITER_W  = 16;
  localparam int THR_FRAC = 12;
  localparam int ENTRY_W = MEAN_W + CNT_W;

  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd4096;
  localparam logic [ITER_W-1:0] ITER_LOAD  = 16'd2;
  localparam logic [ITER_W-1:0] ITER_CHECK = 16'd3;

  // control from the sequencer to the serial datapath
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

  // what the serial datapath hands back after its last step
  typedef struct packed {
    logic              gt;
    logic [MEAN_W-1:0] quo;
  } ser_res_t;

endpackage

/* rtl/rmsd_ram.sv */
module rmsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rmsd_serial.sv */
// bit-serial multiply/compare and restoring divide, one bit per step
module rmsd_serial (
  input  logic                              clk,
  input  rmsd_pkg::ser_ctl_t                ctl,
  input  logic [rmsd_pkg::THR_W-1:0]        thr,
  input  logic [rmsd_pkg::MEAN_W-1:0]       mean,
  input  logic [rmsd_pkg::MEAN_W-1:0]       absdiff,
  input  logic [rmsd_pkg::CNT_W-1:0]        divisor,
  output rmsd_pkg::ser_res_t                res
);

  localparam int MW = rmsd_pkg::MEAN_W;
  localparam int TW = rmsd_pkg::THR_W;
  localparam int CW = rmsd_pkg::CNT_W;
  localparam int FW = rmsd_pkg::THR_FRAC;

  // multiplier: mean bits shift out lsb first, product bits leave the accumulator
  logic [MW-1:0] m_sr_r,   m_sr_nxt;
  logic [TW-1:0] acc_r,    acc_nxt;
  // lhs of the slow test: (absdiff << 12), low 48 bits serial, top bits parallel
  logic [MW-1:0] lhs_sr_r, lhs_sr_nxt;
  logic [FW-1:0] lhs_hi_r, lhs_hi_nxt;
  logic          gt_lo_r,  gt_lo_nxt;
  // divider: dividend shifts out msb first, quotient bits shift in
  logic [MW-1:0] div_sr_r, div_sr_nxt;
  logic [CW-1:0] rem_r,    rem_nxt;

  logic [TW:0]   psum;
  logic          pbit;
  logic [CW:0]   rem_s;
  logic          qbit;
  logic [TW-1:0] hi_lhs;

  always_comb begin
    psum  = {1'b0, acc_r} + (m_sr_r[0] ? {1'b0, thr} : '0);
    pbit  = psum[0];
    rem_s = {rem_r, div_sr_r[MW-1]};
    qbit  = (rem_s >= {1'b0, divisor});

    m_sr_nxt   = m_sr_r;
    acc_nxt    = acc_r;
    lhs_sr_nxt = lhs_sr_r;
    lhs_hi_nxt = lhs_hi_r;
    gt_lo_nxt  = gt_lo_r;
    div_sr_nxt = div_sr_r;
    rem_nxt    = rem_r;

    if (ctl.load) begin
      m_sr_nxt   = mean;
      acc_nxt    = '0;
      lhs_sr_nxt = {absdiff[MW-FW-1:0], {FW{1'b0}}};
      lhs_hi_nxt = absdiff[MW-1:MW-FW];
      gt_lo_nxt  = 1'b0;
      div_sr_nxt = absdiff;
      rem_nxt    = '0;
    end else if (ctl.step) begin
      m_sr_nxt   = {1'b0, m_sr_r[MW-1:1]};
      acc_nxt    = psum[TW:1];
      lhs_sr_nxt = {1'b0, lhs_sr_r[MW-1:1]};
      if (lhs_sr_r[0] != pbit) begin
        gt_lo_nxt = lhs_sr_r[0];
      end
      div_sr_nxt = {div_sr_r[MW-2:0], qbit};
      rem_nxt    = qbit ? CW'(rem_s - {1'b0, divisor}) : rem_s[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    m_sr_r   <= m_sr_nxt;
    acc_r    <= acc_nxt;
    lhs_sr_r <= lhs_sr_nxt;
    lhs_hi_r <= lhs_hi_nxt;
    gt_lo_r  <= gt_lo_nxt;
    div_sr_r <= div_sr_nxt;
    rem_r    <= rem_nxt;
  end

  // top 16 product bits sit in the accumulator after the last step
  always_comb begin
    hi_lhs  = TW'(lhs_hi_r);
    res.gt  = (hi_lhs != acc_r) ? (hi_lhs > acc_r) : gt_lo_r;
    res.quo = div_sr_r;
  end

endmodule

/* rtl/running_mean_slow_detector.sv */
// running_mean_slow_detector
//
// Per-entry running mean of request durations with a slow-outlier flag.
// Input channel (in_valid / in_stall): each request names a table entry by
// stage and slot and carries a duration and an iteration number. Output
// channel (out_valid / out_stall): one result per request, in order, with
// the slow flag, the update flag and the entry mean and count after it.
// Configuration is an APB-style port; register 0 is slow_threshold (Q4.12).
//
// One request at a time. An in-range request passes from accept to the next
// accept through table read, subtract, serial load, then 48 bit-serial
// steps in which a shift-add multiplier (threshold x mean), a serial
// compare and a restoring divider (|d - mean| / count) run side by side,
// then write-back and the idle state that takes the next request. An
// out-of-range request goes from idle straight to write-back. Reset: the
// threshold returns to 1.0 and a clearing pass writes zero into every one
// of the STAGES*SLOTS table entries, with in_stall high meanwhile.
// A stalled result holds in the output register; the next request is
// still taken and worked on, and waits in write-back until the slot frees.
module running_mean_slow_detector #(
  parameter int STAGES = 8,
  parameter int SLOTS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_stage_index,
  input  logic [4:0]  in_slot_index,
  input  logic [31:0] in_duration,
  input  logic [15:0] in_iteration,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_slow,
  output logic        out_table_updated,
  output logic [47:0] out_mean_after,
  output logic [15:0] out_count_after,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MW      = rmsd_pkg::MEAN_W;
  localparam int CW      = rmsd_pkg::CNT_W;
  localparam int DW      = rmsd_pkg::DUR_W;
  localparam int ENTRIES = STAGES * SLOTS;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int STEPS   = MW;
  localparam int STEP_W  = $clog2(STEPS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_RUN  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // control state
  logic [2:0]                   state_r, state_nxt;
  logic [ADDR_W-1:0]            clr_r, clr_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rmsd_pkg::THR_W-1:0]   thr_r, thr_nxt;

  // request and entry payload
  logic [ADDR_W-1:0]            idx_r;
  logic                         bad_r;
  logic [DW-1:0]                dur_r;
  logic [rmsd_pkg::ITER_W-1:0]  iter_r;
  logic [MW-1:0]                m_r;
  logic [CW-1:0]                c_r;
  logic [MW:0]                  sub_r;
  logic                         ge_r;
  logic                         dgt_r;

  // result payload
  logic                         out_is_slow_r;
  logic                         out_table_updated_r;
  logic [MW-1:0]                out_mean_after_r;
  logic [CW-1:0]                out_count_after_r;

  logic                         accept;
  logic                         out_free;
  logic                         in_rng;
  logic [ADDR_W-1:0]            idx_in;
  logic [MW-1:0]                dfx;
  logic [MW-1:0]                absdiff;
  logic [CW-1:0]                cnt_inc;
  logic                         slow_calc;
  logic                         slow;
  logic                         upd;
  logic [MW-1:0]                mean_new;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [rmsd_pkg::ENTRY_W-1:0] ram_wdata;
  logic [rmsd_pkg::ENTRY_W-1:0] ram_rdata;

  rmsd_pkg::ser_ctl_t           ser_ctl;
  rmsd_pkg::ser_res_t           ser_res;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {16'b0, thr_r} : '0;

  assign out_valid         = out_valid_r;
  assign out_is_slow       = out_is_slow_r;
  assign out_table_updated = out_table_updated_r;
  assign out_mean_after    = out_mean_after_r;
  assign out_count_after   = out_count_after_r;

  // entry address from stage and slot
  always_comb begin
    in_rng = (32'(in_stage_index) < STAGES) && (32'(in_slot_index) < SLOTS);
    idx_in = ADDR_W'(32'(in_stage_index) * SLOTS + 32'(in_slot_index));
  end

  // duration in 32.16, magnitude of its distance from the mean
  // sign comes straight from the borrow, valid already in the load cycle
  always_comb begin
    dfx     = {dur_r, {rmsd_pkg::FRAC_W{1'b0}}};
    absdiff = sub_r[MW] ? MW'(~sub_r[MW-1:0] + 1'b1) : sub_r[MW-1:0];
    cnt_inc = (c_r == rmsd_pkg::CNT_MAX) ? c_r : CW'(c_r + 1'b1);
  end

  // slow test and table update decided at write-back
  always_comb begin
    if (m_r == '0) begin
      slow_calc = (dur_r != '0);
    end else begin
      slow_calc = dgt_r && ser_res.gt;
    end
    slow = !bad_r && (iter_r > rmsd_pkg::ITER_CHECK) && slow_calc;
    upd  = !bad_r && !slow && (iter_r >= rmsd_pkg::ITER_LOAD);
    if (iter_r == rmsd_pkg::ITER_LOAD) begin
      mean_new = dfx;
    end else if (ge_r) begin
      mean_new = m_r + ser_res.quo;
    end else begin
      mean_new = m_r - ser_res.quo;
    end
  end

  // table write port: clearing pass after reset, else write-back
  always_comb begin
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == S_FIN) && upd;
      ram_waddr = idx_r;
      ram_wdata = {cnt_inc, mean_new};
    end
  end

  assign ser_ctl.load = (state_r == S_LOAD);
  assign ser_ctl.step = (state_r == S_RUN);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    thr_nxt       = thr_r;

    if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      thr_nxt = pwdata[rmsd_pkg::THR_W-1:0];
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_rng ? S_RD : S_FIN;
        end
      end
      S_RD:   state_nxt = S_PREP;
      S_PREP: state_nxt = S_LOAD;
      S_LOAD: begin
        step_nxt  = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // holds here, rewriting the same entry when it updates, until the output slot frees
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= rmsd_pkg::THR_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= idx_in;
      bad_r  <= !in_rng;
      dur_r  <= in_duration;
      iter_r <= in_iteration;
    end
    if (state_r == S_PREP) begin
      m_r   <= ram_rdata[MW-1:0];
      c_r   <= ram_rdata[rmsd_pkg::ENTRY_W-1:MW];
      sub_r <= {1'b0, dfx} - {1'b0, ram_rdata[MW-1:0]};
    end
    if (state_r == S_LOAD) begin
      ge_r  <= !sub_r[MW];
      dgt_r <= !sub_r[MW] && (sub_r[MW-1:0] != '0);
    end
    if ((state_r == S_FIN) && out_free) begin
      out_is_slow_r       <= slow;
      out_table_updated_r <= upd;
      if (bad_r) begin
        out_mean_after_r  <= '0;
        out_count_after_r <= '0;
      end else if (upd) begin
        out_mean_after_r  <= mean_new;
        out_count_after_r <= cnt_inc;
      end else begin
        out_mean_after_r  <= m_r;
        out_count_after_r <= c_r;
      end
    end
  end

  rmsd_ram #(
    .WIDTH (rmsd_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  rmsd_serial u_serial (
    .clk     (clk),
    .ctl     (ser_ctl),
    .thr     (thr_r),
    .mean    (m_r),
    .absdiff (absdiff),
    .divisor (cnt_inc),
    .res     (ser_res)
  );

endmodule

/* verif/testbench.sv */
module testbench;

  localparam int NUM_STAGES = 8;
  localparam int NUM_SLOTS  = 32;
  localparam int NUM_ENTRIES = NUM_STAGES * NUM_SLOTS;

  // apb byte addresses: register 0 and the first unused slot
  localparam logic [2:0] ADDR_SLOW_THRESHOLD = 3'd0;
  localparam logic [2:0] ADDR_UNUSED         = 3'd4;

  // settle a little longer than a request takes in the block
  localparam int SETTLE_CYCLES = 70;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOT_ENTRIES   = 12;

  typedef struct packed {
    logic                        is_slow;
    logic                        table_updated;
    logic [rmsd_pkg::MEAN_W-1:0] mean_after;
    logic [rmsd_pkg::CNT_W-1:0]  count_after;
  } entry_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_stage_index;
  logic [4:0]  in_slot_index;
  logic [31:0] in_duration;
  logic [15:0] in_iteration;
  logic        out_valid;
  logic        out_stall;
  logic        out_is_slow;
  logic        out_table_updated;
  logic [47:0] out_mean_after;
  logic [15:0] out_count_after;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: per-entry mean and count plus the threshold register
  logic [rmsd_pkg::MEAN_W-1:0] mean_store [NUM_ENTRIES];
  logic [rmsd_pkg::CNT_W-1:0]  count_store [NUM_ENTRIES];
  logic [rmsd_pkg::THR_W-1:0]  threshold_now;

  entry_result_t pending_entry_results [$];
  int error_count;
  int send_gap_pct;
  int recv_stall_pct;

  // working set of entries that get well-formed iteration runs
  logic [2:0]  hot_stage [HOT_ENTRIES];
  logic [4:0]  hot_slot [HOT_ENTRIES];
  logic [31:0] hot_base [HOT_ENTRIES];
  int          hot_iter [HOT_ENTRIES];
  int          hot_run_len [HOT_ENTRIES];
  int          hot_iter_offset [HOT_ENTRIES];

  running_mean_slow_detector #(
    .STAGES(NUM_STAGES),
    .SLOTS (NUM_SLOTS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stage_index   (in_stage_index),
    .in_slot_index    (in_slot_index),
    .in_duration      (in_duration),
    .in_iteration     (in_iteration),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_slow      (out_is_slow),
    .out_table_updated(out_table_updated),
    .out_mean_after   (out_mean_after),
    .out_count_after  (out_count_after),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // slow test first, then the running-mean update of the entry
  function automatic entry_result_t advance_entry(logic [2:0] stage, logic [4:0] slot,
                                                  logic [31:0] duration,
                                                  logic [15:0] iteration);
    entry_result_t res;
    logic [63:0] dur_fx;
    logic [63:0] mean;
    logic [rmsd_pkg::CNT_W-1:0] cnt;
    logic slow;
    int idx;
    res = '0;
    if (int'(stage) >= NUM_STAGES || int'(slot) >= NUM_SLOTS) return res;
    idx = int'(stage) * NUM_SLOTS + int'(slot);
    dur_fx = {16'b0, duration, 16'b0};
    mean = 64'(mean_store[idx]);
    slow = 1'b0;
    if (iteration > rmsd_pkg::ITER_CHECK) begin
      // zero mean: any nonzero duration is an outlier
      if (mean == 64'd0) slow = (dur_fx != 64'd0);
      else if (dur_fx > mean)
        slow = ((dur_fx - mean) << rmsd_pkg::THR_FRAC) > (64'(threshold_now) * mean);
    end
    if (!slow && iteration >= rmsd_pkg::ITER_LOAD) begin
      cnt = count_store[idx];
      if (cnt != rmsd_pkg::CNT_MAX) cnt = cnt + 1'b1;
      count_store[idx] = cnt;
      if (iteration == rmsd_pkg::ITER_LOAD) mean = dur_fx;
      else if (dur_fx >= mean) mean = mean + (dur_fx - mean) / 64'(cnt);
      else mean = mean - (mean - dur_fx) / 64'(cnt);
      mean_store[idx] = mean[rmsd_pkg::MEAN_W-1:0];
      res.table_updated = 1'b1;
    end
    res.is_slow = slow;
    res.mean_after = mean_store[idx];
    res.count_after = count_store[idx];
    return res;
  endfunction

  function automatic logic [31:0] clamp_duration(logic [63:0] value);
    return (value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : value[31:0];
  endfunction

  // present one request, honor sender gaps, predict on accept
  task automatic send_request(logic [2:0] stage, logic [4:0] slot, logic [31:0] duration,
                              logic [15:0] iteration);
    entry_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stage_index <= stage;
    in_slot_index  <= slot;
    in_duration    <= duration;
    in_iteration   <= iteration;
    do @(posedge clk); while (in_stall);
    predicted = advance_entry(stage, slot, duration, iteration);
    pending_entry_results.insert(pending_entry_results.size(), predicted);
  endtask

  task automatic end_requests();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_until_drained();
    while (pending_entry_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SLOW_THRESHOLD) threshold_now = data[rmsd_pkg::THR_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check_threshold();
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SLOW_THRESHOLD;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== {16'b0, threshold_now}) begin
      $error("slow_threshold mismatch: expected %h, got %h", {16'b0, threshold_now}, got);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(logic [15:0] value);
    apb_write(ADDR_SLOW_THRESHOLD, {16'($urandom), value});
    apb_check_threshold();
  endtask

  // well-formed iteration runs on hot entries, with some noise mixed in
  task automatic random_traffic(int n_items);
    int h;
    int kind;
    int iter_num;
    logic [31:0] base;
    logic [31:0] jitter;
    logic [31:0] dur;
    for (int i = 0; i < HOT_ENTRIES; i++) begin
      hot_stage[i] = 3'($urandom);
      hot_slot[i] = 5'($urandom);
      hot_base[i] = $urandom >> $urandom_range(0, 28);
      hot_iter[i] = $urandom_range(0, 2);
      hot_run_len[i] = $urandom_range(6, 60);
      hot_iter_offset[i] = ($urandom_range(3) == 0) ? $urandom_range(0, 65400) : 0;
    end
    for (int n = 0; n < n_items; n++) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        h = $urandom_range(0, HOT_ENTRIES - 1);
        base = hot_base[h];
        jitter = base >> 3;
        if (kind < 6) dur = clamp_duration(64'(base) * $urandom_range(2, 6));
        else if (kind < 8) dur = 32'd0;
        else dur = clamp_duration(64'(base) - 64'(jitter) + $urandom_range(0, 2 * jitter));
        iter_num = (hot_iter[h] < 4) ? hot_iter[h] : hot_iter[h] + hot_iter_offset[h];
        send_request(hot_stage[h], hot_slot[h], dur, 16'(iter_num));
        hot_iter[h]++;
        if (hot_iter[h] > hot_run_len[h]) begin
          // restart the run, sometimes on a fresh entry
          hot_iter[h] = $urandom_range(0, 2);
          hot_base[h] = $urandom >> $urandom_range(0, 28);
          hot_run_len[h] = $urandom_range(6, 60);
          if ($urandom_range(1) == 1) begin
            hot_stage[h] = 3'($urandom);
            hot_slot[h] = 5'($urandom);
          end
        end
      end else begin
        send_request(3'($urandom), 5'($urandom), $urandom,
                     ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 5)));
      end
    end
    end_requests();
  endtask

  task automatic test_register_access();
    apb_check_threshold();
    // writes to the unused address leave the threshold alone
    apb_write(ADDR_UNUSED, $urandom);
    apb_check_threshold();
  endtask

  task automatic test_directed_cases();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    // iterations below two leave the entry alone
    send_request(3'd0, 5'd0, 32'd100, 16'd0);
    send_request(3'd0, 5'd0, 32'd5, 16'd1);
    // zero mean: zero duration passes and updates, nonzero is slow
    send_request(3'd0, 5'd0, 32'd0, 16'd4);
    send_request(3'd0, 5'd0, 32'd7, 16'd5);
    // first update above iteration two on an empty entry takes the duration
    send_request(3'd7, 5'd31, 32'd1000, 16'd3);
    // exactly double the mean at threshold 1.0 is not slow, just above is
    send_request(3'd7, 5'd31, 32'd2000, 16'd4);
    send_request(3'd7, 5'd31, 32'd3001, 16'd4);
    send_request(3'd7, 5'd31, 32'd3000, 16'd4);
    // duration extremes with a load and the top iteration
    send_request(3'd3, 5'd16, 32'hFFFF_FFFF, rmsd_pkg::ITER_LOAD);
    send_request(3'd3, 5'd16, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(3'd3, 5'd16, 32'd0, 16'hFFFF);
    send_request(3'd3, 5'd16, 32'd0, rmsd_pkg::ITER_LOAD);
    // small steps where the truncated division matters
    send_request(3'd5, 5'd10, 32'd12345, rmsd_pkg::ITER_LOAD);
    send_request(3'd5, 5'd10, 32'd12340, rmsd_pkg::ITER_CHECK);
    send_request(3'd5, 5'd10, 32'd12350, 16'd6);
    end_requests();
    wait_until_drained();
    // zero threshold: any excess over the mean is slow
    set_threshold(16'd0);
    send_request(3'd5, 5'd10, 32'd12346, 16'd8);
    send_request(3'd5, 5'd10, 32'd12000, 16'd8);
    send_request(3'd7, 5'd31, 32'd4000, 16'd3);
    end_requests();
    wait_until_drained();
    // maximum threshold, just under 16x
    set_threshold(16'hFFFF);
    send_request(3'd7, 5'd31, 32'd40000, 16'd9);
    send_request(3'd7, 5'd31, 32'd30000, 16'd9);
    send_request(3'd0, 5'd0, 32'hFFFF_FFFF, 16'd10);
    end_requests();
    wait_until_drained();
  endtask

  task automatic test_random_phases();
    int gap_pcts [4];
    int stall_pcts [4];
    logic [15:0] thresholds [4];
    gap_pcts = '{0, 46, 0, 32};
    stall_pcts = '{0, 0, 46, 32};
    thresholds = '{rmsd_pkg::THR_RESET, 16'($urandom), 16'd2048, 16'd12288};
    for (int p = 0; p < 4; p++) begin
      wait_until_drained();
      set_threshold(thresholds[p]);
      send_gap_pct = gap_pcts[p];
      recv_stall_pct = stall_pcts[p];
      random_traffic(440);
    end
  endtask

  // sender holds off until every result is back, then resumes
  task automatic test_drain_pause();
    send_gap_pct = 32;
    recv_stall_pct = 32;
    random_traffic(30);
    while (pending_entry_results.size() != 0) @(posedge clk);
    random_traffic(30);
  endtask

  // receiver stalls at random, decided every cycle
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    entry_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_entry_results.size() == 0) begin
        $error("unexpected result: mean_after %h count_after %h", out_mean_after,
               out_count_after);
        error_count++;
      end else begin
        want = pending_entry_results.pop_front();
        if (out_is_slow !== want.is_slow) begin
          $error("is_slow mismatch: expected %b, got %b", want.is_slow, out_is_slow);
          error_count++;
        end
        if (out_table_updated !== want.table_updated) begin
          $error("table_updated mismatch: expected %b, got %b", want.table_updated,
                 out_table_updated);
          error_count++;
        end
        if (out_mean_after !== want.mean_after) begin
          $error("mean_after mismatch: expected %h, got %h", want.mean_after, out_mean_after);
          error_count++;
        end
        if (out_count_after !== want.count_after) begin
          $error("count_after mismatch: expected %h, got %h", want.count_after,
                 out_count_after);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stage_index = '0;
    in_slot_index = '0;
    in_duration = '0;
    in_iteration = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    threshold_now = rmsd_pkg::THR_RESET;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      mean_store[i] = '0;
      count_store[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed_cases();
    test_random_phases();
    test_drain_pause();

    wait_until_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rmsd_pkg.sv
rtl/rmsd_ram.sv
rtl/rmsd_serial.sv
rtl/running_mean_slow_detector.sv
verif/testbench.sv
